### rtl/combining_mark_reorder_macros.svh
// Assertion macros shared by the reorder block.
`ifndef COMBINING_MARK_REORDER_MACROS_SVH
`define COMBINING_MARK_REORDER_MACROS_SVH

`ifndef ASSERT_OFF
`define CMR_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
    else $error("assertion failed");
`define CMR_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("implication failed");
`define CMR_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("next-cycle implication failed");
`else
`define CMR_ASSERT(lbl, clk, rstn, prop)
`define CMR_ASSERT_IMP(lbl, clk, rstn, ante, cons)
`define CMR_ASSERT_NEXT(lbl, clk, rstn, ante, cons)
`endif

`endif

### rtl/cmr_pkg.sv
package cmr_pkg;

  localparam int unsigned CpW  = 21;
  localparam int unsigned ClsW = 8;
  localparam int unsigned CapW = 16;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_OVERFLOW = 2'd1;
  localparam logic [1:0] ST_CAPACITY = 2'd2;

  typedef struct packed {
    logic [CpW-1:0]  code_point;
    logic [ClsW-1:0] combining_class;
    logic            last_of_string;
  } in_item_t;

  typedef struct packed {
    logic [CpW-1:0] out_code_point;
    logic [1:0]     status;
    logic           last_of_burst;
    logic           string_done;
  } out_item_t;

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_FLUSH = 4'b0010,
    S_START = 4'b0100,
    S_ERR   = 4'b1000
  } state_e;

  // controller -> datapath
  typedef struct packed {
    logic take;
    logic insert;
    logic commit;
    logic abort_ovf;
    logic abort_cap;
    logic shift;
    logic show_run;
    logic show_start;
    logic show_err;
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic is_mark;
    logic is_last;
    logic full;
    logic cap_exceed;
    logic run_after_empty;
    logic run_one;
    logic item_start;
  } stat_t;

endpackage

### rtl/cmr_ctrl.sv
module cmr_ctrl
  import cmr_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  in_valid_i,
  input  logic  out_ready_i,
  input  stat_t stat_i,
  output cmd_t  cmd_o,
  output logic  in_ready_o,
  output logic  out_valid_o
);

  state_e state_q, state_d;
  logic   take, out_xfer, go_flush;

  always_comb begin
    in_ready_o  = (state_q == S_IDLE);
    out_valid_o = (state_q != S_IDLE);
    take        = in_valid_i && in_ready_o;
    out_xfer    = out_valid_o && out_ready_i;
    // starter, or a mark that ends the string, releases the run
    go_flush    = take && !(stat_i.is_mark && stat_i.full) &&
                  (!stat_i.is_mark || stat_i.is_last);

    cmd_o            = '0;
    cmd_o.take       = take;
    cmd_o.insert     = take && stat_i.is_mark && !stat_i.full;
    cmd_o.abort_ovf  = take && stat_i.is_mark && stat_i.full;
    cmd_o.abort_cap  = go_flush && stat_i.cap_exceed;
    cmd_o.commit     = go_flush && !stat_i.cap_exceed;
    cmd_o.shift      = (state_q == S_FLUSH) && out_xfer;
    cmd_o.show_run   = (state_q == S_FLUSH);
    cmd_o.show_start = (state_q == S_START);
    cmd_o.show_err   = (state_q == S_ERR);

    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (cmd_o.abort_ovf || cmd_o.abort_cap) begin
          state_d = S_ERR;
        end else if (cmd_o.commit) begin
          state_d = stat_i.run_after_empty ? S_START : S_FLUSH;
        end
      end
      S_FLUSH: begin
        if (out_xfer && stat_i.run_one) begin
          state_d = stat_i.item_start ? S_START : S_IDLE;
        end
      end
      S_START: begin
        if (out_xfer) state_d = S_IDLE;
      end
      S_ERR: begin
        if (out_xfer) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

### rtl/cmr_datapath.sv
module cmr_datapath
  import cmr_pkg::*;
#(
  parameter int unsigned RUN_DEPTH = 32
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            cfg_we_i,
  input  logic [CapW-1:0] cfg_wdata_i,
  input  in_item_t        in_item_i,
  input  cmd_t            cmd_i,
  output stat_t           stat_o,
  output out_item_t       out_item_o
);

  localparam int unsigned CntW = $clog2(RUN_DEPTH + 1);
  localparam int unsigned BW   = CapW + 1;

  logic [CpW-1:0]  pts_q [RUN_DEPTH];
  logic [CpW-1:0]  pts_d [RUN_DEPTH];
  logic [ClsW-1:0] cls_q [RUN_DEPTH];
  logic [ClsW-1:0] cls_d [RUN_DEPTH];
  logic [RUN_DEPTH-1:0] gt;

  logic [CntW-1:0] count_q, count_d, count_after;
  logic [CapW-1:0] emitted_q, emitted_d;
  logic [CapW-1:0] cap_q;
  logic [CpW-1:0]  item_cp_q;
  logic            item_start_q, item_last_q;
  logic [1:0]      err_st_q;
  logic [BW-1:0]   burst;
  logic            is_mark, shift_in, place;

  always_comb begin
    is_mark     = (in_item_i.combining_class != '0);
    count_after = count_q + CntW'(is_mark);
    burst       = BW'(count_after) + BW'(!is_mark);

    stat_o.is_mark         = is_mark;
    stat_o.is_last         = in_item_i.last_of_string;
    stat_o.full            = (count_q == CntW'(RUN_DEPTH));
    stat_o.cap_exceed      = (BW'(emitted_q) + burst) > BW'(cap_q);
    stat_o.run_after_empty = (count_after == '0);
    stat_o.run_one         = (count_q == CntW'(1));
    stat_o.item_start      = item_start_q;
  end

  // stable insert: held marks of higher class move up one slot
  always_comb begin
    for (int j = 0; j < RUN_DEPTH; j++) begin
      gt[j] = (CntW'(j) < count_q) && (cls_q[j] > in_item_i.combining_class);
    end
    for (int j = 0; j < RUN_DEPTH; j++) begin
      pts_d[j] = pts_q[j];
      cls_d[j] = cls_q[j];
      shift_in = 1'b0;
      if (j > 0) shift_in = gt[j-1];
      place = !shift_in && (gt[j] || (CntW'(j) == count_q));
      if (cmd_i.insert) begin
        if (shift_in) begin
          pts_d[j] = pts_q[(j > 0) ? j - 1 : 0];
          cls_d[j] = cls_q[(j > 0) ? j - 1 : 0];
        end else if (place) begin
          pts_d[j] = in_item_i.code_point;
          cls_d[j] = in_item_i.combining_class;
        end
      end else if (cmd_i.shift && (j < RUN_DEPTH - 1)) begin
        pts_d[j] = pts_q[(j < RUN_DEPTH - 1) ? j + 1 : j];
        cls_d[j] = cls_q[(j < RUN_DEPTH - 1) ? j + 1 : j];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    for (int j = 0; j < RUN_DEPTH; j++) begin
      pts_q[j] <= pts_d[j];
      cls_q[j] <= cls_d[j];
    end
    if (cmd_i.take) begin
      item_cp_q    <= in_item_i.code_point;
      item_start_q <= !is_mark;
      item_last_q  <= in_item_i.last_of_string;
    end
    if (cmd_i.abort_ovf) begin
      err_st_q <= ST_OVERFLOW;
    end else if (cmd_i.abort_cap) begin
      err_st_q <= ST_CAPACITY;
    end
  end

  always_comb begin
    count_d   = count_q;
    emitted_d = emitted_q;
    if (cmd_i.abort_ovf || cmd_i.abort_cap) begin
      count_d   = '0;
      emitted_d = '0;
    end else begin
      if (cmd_i.insert) begin
        count_d = count_q + CntW'(1);
      end else if (cmd_i.shift) begin
        count_d = count_q - CntW'(1);
      end
      if (cmd_i.commit) begin
        emitted_d = in_item_i.last_of_string ? '0 : (emitted_q + burst[CapW-1:0]);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q   <= '0;
      emitted_q <= '0;
      cap_q     <= '1;
    end else begin
      count_q   <= count_d;
      emitted_q <= emitted_d;
      if (cfg_we_i) cap_q <= cfg_wdata_i;
    end
  end

  always_comb begin
    out_item_o.out_code_point = '0;
    out_item_o.status         = ST_OK;
    out_item_o.last_of_burst  = 1'b1;
    out_item_o.string_done    = 1'b1;
    if (cmd_i.show_run) begin
      out_item_o.out_code_point = pts_q[0];
      out_item_o.status         = ST_OK;
      out_item_o.last_of_burst  = stat_o.run_one && !item_start_q;
      out_item_o.string_done    = stat_o.run_one && !item_start_q && item_last_q;
    end else if (cmd_i.show_start) begin
      out_item_o.out_code_point = item_cp_q;
      out_item_o.status         = ST_OK;
      out_item_o.string_done    = item_last_q;
    end else if (cmd_i.show_err) begin
      out_item_o.status         = err_st_q;
    end
  end

endmodule

### rtl/combining_mark_reorder.sv
// A mark that does not end the string is absorbed in its transfer cycle.
// A flushing item is taken, then the drain gives one result per cycle while the receiver is
// ready: a run of n marks plus a starter gives n+1 results.
// Items are taken one at a time: no new input is accepted while results are shown.
// Reset: control, run count and emitted count clear, capacity returns to 65535; the run
// buffer holds no reset and needs no clearing pass.
`include "combining_mark_reorder_macros.svh"

module combining_mark_reorder
  import cmr_pkg::*;
#(
  parameter int unsigned RUN_DEPTH = 32
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            cfg_we_i,
  input  logic [CapW-1:0] cfg_wdata_i,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  in_item_t        in_item_i,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output out_item_t       out_item_o
);

  cmd_t  cmd;
  stat_t stat;

  // Controller: accept items while idle, sequence the flush one transfer at a time,
  // and hold error results until they are taken.
  cmr_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .out_ready_i(out_ready_i),
    .stat_i     (stat),
    .cmd_o      (cmd),
    .in_ready_o (in_ready_o),
    .out_valid_o(out_valid_o)
  );

  // Datapath: sorted run buffer with parallel compare-shift insert, shift-out drain,
  // string counters, capacity register and result formatting.
  cmr_datapath #(
    .RUN_DEPTH(RUN_DEPTH)
  ) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .in_item_i  (in_item_i),
    .cmd_i      (cmd),
    .stat_o     (stat),
    .out_item_o (out_item_o)
  );

  // Input and output sides never transfer in the same cycle.
  `CMR_ASSERT(a_no_overlap, clk_i, rst_ni, !(in_ready_o && out_valid_o))
  // Never insert into a full run.
  `CMR_ASSERT_IMP(a_insert_room, clk_i, rst_ni, cmd.insert, !stat.full)
  // An abort shows an error result that ends the string.
  `CMR_ASSERT_NEXT(a_abort_result, clk_i, rst_ni, cmd.abort_ovf || cmd.abort_cap,
                   out_valid_o && out_item_o.string_done && (out_item_o.status != ST_OK))
  // After the final transfer of a burst, return to accepting input.
  `CMR_ASSERT_NEXT(a_burst_end_idle, clk_i, rst_ni,
                   out_valid_o && out_ready_i && out_item_o.last_of_burst, in_ready_o)

endmodule

### tb/tb_combining_mark_reorder.sv
module tb_combining_mark_reorder
  import cmr_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned RUN_SLOTS = 32;

  // Idle cycles after the last expected result before a capacity write or the verdict.
  // Covers an absorbed mark that produces nothing plus the longest flush.
  localparam int unsigned SETTLE_CYCLES = 48;

  // Length of the one long receiver hold-off, and the input count that triggers it.
  localparam int unsigned HOLD_CYCLES = 300;
  localparam int unsigned HOLD_AFTER = 60;

  logic            clk_i = 1'b0;
  logic            rst_ni = 1'b0;
  logic            cfg_we_i = 1'b0;
  logic [CapW-1:0] cfg_wdata_i = '0;
  logic            in_valid_i = 1'b0;
  logic            in_ready_o;
  in_item_t        in_item_i = '0;
  logic            out_valid_o;
  logic            out_ready_i = 1'b0;
  out_item_t       out_item_o;

  combining_mark_reorder #(
    .RUN_DEPTH(RUN_SLOTS)
  ) uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_item_i  (in_item_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_item_o (out_item_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Code points waiting to be offered, and reordered results still owed by the block.
  in_item_t  pending_points[$];
  out_item_t owed_results[$];

  int unsigned mismatches = 0;
  int unsigned results_seen = 0;
  int unsigned points_taken = 0;

  // Code points put on the input so far, owned by the driver; the current one has
  // transferred once the taken count catches up.
  int unsigned points_offered = 0;

  // Last part of the run: no idling on either side.
  logic steady = 1'b0;

  // Receiver-side stall state, owned by the ready process.
  int unsigned hold_left = 0;
  int unsigned stall_left = 0;
  logic        hold_used = 1'b0;

  // Sender-side gap state, owned by the driver.
  int unsigned gap_left = 0;

  // ---------------------------------------------------------------------------
  // Canonical ordering predictor: a mirror of the mark run, the per-string
  // output count and the capacity register.
  // ---------------------------------------------------------------------------
  logic [CpW-1:0]  mark_points [RUN_SLOTS];
  logic [ClsW-1:0] mark_classes[RUN_SLOTS];
  int unsigned     marks_held = 0;
  logic [CapW-1:0] points_written = '0;
  logic [CapW-1:0] capacity_limit = 16'hFFFF;

  function automatic out_item_t mk_result(logic [CpW-1:0] cp, logic [1:0] st, logic eob,
                                          logic done);
    out_item_t r;
    r.out_code_point = cp;
    r.status         = st;
    r.last_of_burst  = eob;
    r.string_done    = done;
    return r;
  endfunction

  task automatic predict_reorder(in_item_t it);
    int unsigned pos;
    int unsigned burst;
    int unsigned i;
    if (it.combining_class != '0) begin
      // A mark into a full run aborts the string.
      if (marks_held >= RUN_SLOTS) begin
        owed_results.push_back(mk_result('0, ST_OVERFLOW, 1'b1, 1'b1));
        marks_held = 0;
        points_written = '0;
        return;
      end
      // Stable insert: slide every held mark of higher class up by one.
      pos = marks_held;
      while (pos > 0 && mark_classes[pos-1] > it.combining_class) begin
        mark_points[pos]  = mark_points[pos-1];
        mark_classes[pos] = mark_classes[pos-1];
        pos--;
      end
      mark_points[pos]  = it.code_point;
      mark_classes[pos] = it.combining_class;
      marks_held++;
      if (!it.last_of_string) return;
    end

    // Flush: the whole burst must fit, or nothing of it is written.
    burst = marks_held + ((it.combining_class == '0) ? 1 : 0);
    if (int'(points_written) + burst > int'(capacity_limit)) begin
      owed_results.push_back(mk_result('0, ST_CAPACITY, 1'b1, 1'b1));
      marks_held = 0;
      points_written = '0;
      return;
    end
    for (i = 0; i < marks_held; i++)
      owed_results.push_back(mk_result(mark_points[i], ST_OK, i + 1 == burst,
                                       (i + 1 == burst) && it.last_of_string));
    if (it.combining_class == '0)
      owed_results.push_back(mk_result(it.code_point, ST_OK, 1'b1, it.last_of_string));
    marks_held = 0;
    points_written = it.last_of_string ? '0 : points_written + CapW'(burst);
  endtask

  task automatic report_mismatch(string msg);
    $display("[%0t] result %0d: %s", $realtime, results_seen, msg);
    mismatches++;
  endtask

  // ---------------------------------------------------------------------------
  // Scoreboard: predict on every input transfer, then check every output
  // transfer against the oldest owed result. Prediction comes first so a
  // same-edge pass-through still finds its expectation.
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    out_item_t want;
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) begin
        predict_reorder(in_item_i);
        points_taken++;
      end
      if (out_valid_o && out_ready_i) begin
        results_seen++;
        if (owed_results.size() == 0) begin
          report_mismatch($sformatf("unexpected result cp %06h status %0d",
                                    out_item_o.out_code_point, out_item_o.status));
        end else begin
          want = owed_results.pop_front();
          if (out_item_o.out_code_point !== want.out_code_point)
            report_mismatch($sformatf("code point got %06h want %06h",
                                      out_item_o.out_code_point, want.out_code_point));
          if (out_item_o.status !== want.status)
            report_mismatch($sformatf("status got %0d want %0d",
                                      out_item_o.status, want.status));
          if (out_item_o.last_of_burst !== want.last_of_burst)
            report_mismatch($sformatf("last_of_burst got %0b want %0b",
                                      out_item_o.last_of_burst, want.last_of_burst));
          if (out_item_o.string_done !== want.string_done)
            report_mismatch($sformatf("string_done got %0b want %0b",
                                      out_item_o.string_done, want.string_done));
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Driver: advance to the next code point only once the current one has
  // transferred. Insert random gaps between transfers, but never while the
  // receiver holds off, so the block backs up.
  // ---------------------------------------------------------------------------
  always @(negedge clk_i) begin
    if (rst_ni && (points_taken == points_offered)) begin
      if (gap_left > 0) begin
        gap_left--;
        in_valid_i <= 1'b0;
      end else if (!steady && hold_left == 0 && pending_points.size() > 0 &&
                   $urandom_range(0, 7) == 0) begin
        gap_left = $urandom_range(1, 14) - 1;
        in_valid_i <= 1'b0;
      end else if (pending_points.size() > 0) begin
        in_item_i  <= pending_points.pop_front();
        in_valid_i <= 1'b1;
        points_offered++;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Receiver: one long hold-off once enough input has gone in, then random
  // stall bursts until the quiet tail of the run.
  // ---------------------------------------------------------------------------
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (hold_left > 0) begin
        hold_left--;
        out_ready_i <= 1'b0;
      end else if (!hold_used && points_taken >= HOLD_AFTER) begin
        hold_used = 1'b1;
        hold_left = HOLD_CYCLES - 1;
        out_ready_i <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        out_ready_i <= 1'b0;
      end else if (!steady && $urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(1, 14) - 1;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  task automatic add_point(logic [CpW-1:0] cp, logic [ClsW-1:0] cls, logic last);
    in_item_t it;
    it.code_point      = cp;
    it.combining_class = cls;
    it.last_of_string  = last;
    pending_points.push_back(it);
  endtask

  // Mostly valid scalars, sometimes anything that fits the 21-bit field.
  function automatic logic [CpW-1:0] rand_cp();
    if ($urandom_range(0, 3) == 0) return CpW'($urandom());
    return CpW'($urandom_range(0, 'h10FFFF));
  endfunction

  // Favor a few common classes so that ties show up often.
  function automatic logic [ClsW-1:0] rand_mark_class();
    case ($urandom_range(0, 7))
      0:       return 8'd220;
      1, 2:    return 8'd230;
      3:       return 8'd1;
      4:       return 8'd255;
      default: return ClsW'($urandom_range(1, 255));
    endcase
  endfunction

  // Queue a marked run of the given length, ending the string either on the
  // last mark or on a trailing starter.
  task automatic add_mark_run(int unsigned marks, logic end_on_mark);
    int unsigned k;
    for (k = 0; k < marks; k++)
      add_point(rand_cp(), rand_mark_class(), end_on_mark && k == marks - 1);
    if (!end_on_mark) add_point(rand_cp(), '0, 1'b1);
  endtask

  // Fill with whole strings: mostly short text, some long and overflowing
  // runs, and a little noise.
  task automatic queue_text(int unsigned budget);
    int unsigned added;
    int unsigned kind;
    int unsigned len;
    int unsigned k;
    added = 0;
    while (added < budget) begin
      kind = $urandom_range(0, 99);
      if (kind < 60) begin
        len = $urandom_range(1, 10);
        for (k = 0; k < len; k++)
          add_point(rand_cp(), ($urandom_range(0, 99) < 45) ? '0 : rand_mark_class(),
                    k == len - 1);
        added += len;
      end else if (kind < 72) begin
        len = $urandom_range(16, RUN_SLOTS);
        add_point(rand_cp(), '0, 1'b0);
        add_mark_run(len, 1'($urandom_range(0, 1)));
        added += len + 2;
      end else if (kind < 80) begin
        // The mark after a full run aborts; later marks open a new string.
        len = $urandom_range(RUN_SLOTS + 1, RUN_SLOTS + 3);
        add_mark_run(len, 1'b0);
        added += len + 1;
      end else begin
        len = $urandom_range(1, 6);
        for (k = 0; k < len; k++)
          add_point(rand_cp(), ClsW'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
        // Close the string so the block is idle at the end of the phase.
        add_point(rand_cp(), '0, 1'b1);
        added += len + 1;
      end
    end
  endtask

  // Wait until every code point has transferred and every result has come
  // back, then let the block settle.
  task automatic drain_block();
    while (pending_points.size() != 0 || in_valid_i || owed_results.size() != 0)
      @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // Write the capacity register while the block is idle.
  task automatic write_capacity(logic [CapW-1:0] value);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    capacity_limit = value;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // Test sequence
  // ---------------------------------------------------------------------------
  initial begin
    repeat (12) @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed text at the reset capacity.
    add_point('0, '0, 1'b0);                // lone starter, smallest code point
    add_point(21'h10FFFF, '0, 1'b1);        // largest scalar ends the string
    add_point(21'h1FFFFF, 8'd255, 1'b1);    // mark that ends the string by itself
    add_point(21'h000301, 8'd230, 1'b0);    // absorbed marks, out of order
    add_point(21'h000316, 8'd220, 1'b0);
    add_point(21'h000302, 8'd230, 1'b0);    // ties with the first mark
    add_point(21'h000327, 8'd202, 1'b0);
    add_point(21'h000001, 8'd1, 1'b0);
    add_point(21'h000041, '0, 1'b0);        // starter flushes the sorted run
    add_point(21'h110000, '0, 1'b0);        // above the scalar range, passed through
    add_point(21'h1AAAAA, 8'd128, 1'b0);
    add_point(21'h155555, 8'd128, 1'b1);    // equal-class marks, string ends on a mark
    add_point(21'h0AAAAA, 8'd7, 1'b0);
    add_point(21'h0FFFFF, '0, 1'b1);        // starter that ends the string after a mark
    drain_block();

    // Largest capacity; the long receiver hold-off lands in this phase.
    write_capacity(16'hFFFF);
    queue_text(110);
    drain_block();

    // Capacity of one: a second output in any string aborts it.
    write_capacity(16'd1);
    add_point(rand_cp(), '0, 1'b0);
    add_point(rand_cp(), '0, 1'b1);
    queue_text(40);
    drain_block();

    // Small capacity: long runs overrun it.
    write_capacity(CapW'($urandom_range(2, 40)));
    queue_text(50);
    drain_block();

    write_capacity(CapW'($urandom_range(1, 65535)));
    queue_text(50);
    drain_block();

    // Capacity just fits a full run plus its starter; one more output does not.
    write_capacity(16'd33);
    add_mark_run(RUN_SLOTS, 1'b0);
    add_point(rand_cp(), '0, 1'b0);
    add_mark_run(RUN_SLOTS, 1'b0);
    add_mark_run(RUN_SLOTS + 1, 1'b1);      // string ends on the mark that overflows
    queue_text(30);
    drain_block();

    // Quiet tail: no idling on either side.
    write_capacity(16'hFFFF);
    steady = 1'b1;
    queue_text(60);
    drain_block();

    if (mismatches == 0 && owed_results.size() == 0) begin
      $display("tb_combining_mark_reorder passed");
    end else begin
      $display("tb_combining_mark_reorder failed");
    end
    $finish;
  end

  // Hard stop far beyond the slowest legal run.
  initial begin
    #5_000_000;
    $display("tb_combining_mark_reorder failed");
    $finish;
  end

endmodule

### files.f
+incdir+rtl
rtl/cmr_pkg.sv
rtl/cmr_ctrl.sv
rtl/cmr_datapath.sv
rtl/combining_mark_reorder.sv
tb/tb_combining_mark_reorder.sv
